FILE: src/tcp_receive_bitmap_sack_gen_defines.svh
// Assertion macros for the SACK generator
`ifndef TCP_RECEIVE_BITMAP_SACK_GEN_DEFINES_SVH
`define TCP_RECEIVE_BITMAP_SACK_GEN_DEFINES_SVH

// Condition must never hold outside reset
`define TRBS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TRBS_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define TRBS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/trbsg_pkg.sv
// Types, codes and bit-search helpers for the SACK generator
package trbsg_pkg;

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_CHK      = 13'b0000000000100,
    S_WIN      = 13'b0000000001000,
    S_MARK_RD  = 13'b0000000010000,
    S_MARK_WR  = 13'b0000000100000,
    S_ADV_RD   = 13'b0000001000000,
    S_ADV_EV   = 13'b0000010000000,
    S_SCAN_CHK = 13'b0000100000000,
    S_SCAN_RD  = 13'b0001000000000,
    S_SCAN_EV  = 13'b0010000000000,
    S_OUT_RD   = 13'b0100000000000,
    S_OUT_SEND = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_BUF_OVF  = 2'd2,
    ST_HOLES    = 2'd3
  } status_t;

  localparam logic [1:0] REG_INITIAL_SEQ  = 2'd0;
  localparam logic [1:0] REG_RECV_WINDOW  = 2'd1;
  localparam logic [1:0] REG_MAX_SEG_SIZE = 2'd2;
  localparam logic [1:0] REG_BUFFER_LIMIT = 2'd3;

  localparam int WORD_BITS = 64;

  // Count of ones from bit 0 upward until the first zero
  function automatic logic [6:0] trailing_ones(input logic [63:0] v);
    logic [6:0] r;
    r = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (!v[i]) r = 7'(i);
    end
    return r;
  endfunction

  // Index of the highest set bit, zero for an empty word
  function automatic logic [5:0] highest_set(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

FILE: src/tcp_receive_bitmap_sack_gen.sv
// TCP receive bitmap with cumulative ack and SACK block generation
// Each segment goes through the checks, then a read and a write per bitmap word marked, a
// read and an evaluation per word advanced over, a scan read and evaluation per word scanned
// plus an evaluation per block edge, and a read and send per block result (a send alone
// without blocks). One segment at a time; all steps share the single bitmap memory port.
// Reset and each initial_seq write clear the map, taking no segment.
`include "tcp_receive_bitmap_sack_gen_defines.svh"

module tcp_receive_bitmap_sack_gen #(
  parameter int BUFFER_BYTES = 65536,
  parameter int MAX_BLOCKS   = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // segment_seq[31:0], payload_len[47:32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // ack_number[31:0], left_edge[63:32],
                                  // right_edge[95:64], status[97:96], zero pad
  output logic         m_tuser,   // block_valid
  output logic         m_tlast
);
  import trbsg_pkg::*;

  localparam int ADDR_W    = $clog2(BUFFER_BYTES);
  localparam int LIM_W     = ADDR_W + 1;
  localparam int WIDX_W    = ADDR_W - 6;
  localparam int MAP_WORDS = (BUFFER_BYTES + WORD_BITS - 1) / WORD_BITS;
  localparam int NB_W      = $clog2(MAX_BLOCKS + 1);
  localparam int BIDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  state_t state;

  logic [31:0] initial_seq;
  logic [15:0] recv_window;
  logic [15:0] max_seg_size;
  logic [16:0] buffer_limit;

  logic [31:0] next_expected;
  logic [31:0] highest_seen;

  logic [31:0] seq_r;
  logic [15:0] len_r;
  logic [31:0] seg_end;
  logic [31:0] last_byte;
  logic [31:0] wend;
  logic [31:0] s_off;

  logic [WIDX_W-1:0] mark_w;
  logic [ADDR_W-1:0] mark_lo;
  logic [ADDR_W-1:0] mark_hi;
  logic [ADDR_W-1:0] adv_off;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] right_off;
  logic              hole;
  logic [NB_W-1:0]   nb;
  logic [NB_W-1:0]   out_idx;
  status_t           res_status;
  logic              res_blk;
  logic [WIDX_W-1:0] clr_idx;

  logic [63:0] map_mem [MAP_WORDS];
  logic [63:0] map_rd;
  logic        map_we;
  logic        map_re;
  logic [WIDX_W-1:0] map_waddr;
  logic [WIDX_W-1:0] map_raddr;
  logic [63:0] map_wdata;

  logic [63:0] blk_mem [MAX_BLOCKS];
  logic [63:0] blk_rd;
  logic        blk_we;
  logic [63:0] blk_wdata;

  // Derived values
  logic [31:0]  lim32;
  logic [LIM_W-1:0] lim;
  logic [31:0]  adv_cur;
  logic [31:0]  top_off;
  logic [32:0]  me33;
  logic [31:0]  ms;
  logic [31:0]  mend;
  logic         win_ok;
  logic [63:0]  lo_mask;
  logic [63:0]  hi_mask;
  logic [63:0]  adv_word;
  logic [6:0]   adv_ones;
  logic [LIM_W-1:0] adv_avail;
  logic [LIM_W-1:0] adv_amt;
  logic [63:0]  scan_mask;
  logic [63:0]  scan_cand;
  logic [5:0]   scan_bit;
  logic [ADDR_W-1:0] scan_p;
  logic [WIDX_W-1:0] scan_word;
  logic         out_last;

  assign lim32 = (32'(buffer_limit) < 32'(BUFFER_BYTES)) ? 32'(buffer_limit)
                                                         : 32'(BUFFER_BYTES);
  assign lim   = lim32[LIM_W-1:0];

  assign adv_cur = next_expected - initial_seq;
  assign top_off = highest_seen - initial_seq;

  // Marking range, wrapped part folded to offset zero and clipped to the limit
  assign me33   = {1'b0, s_off} + 33'(len_r);
  assign ms     = me33[32] ? 32'd0 : s_off;
  assign mend   = (me33[31:0] < lim32) ? me33[31:0] : lim32;
  assign win_ok = (next_expected <= seq_r) && (seq_r < wend) &&
                  (next_expected <= seg_end) && (last_byte < wend);

  assign lo_mask = (mark_w == mark_lo[ADDR_W-1:6]) ? ({64{1'b1}} << mark_lo[5:0])
                                                   : {64{1'b1}};
  assign hi_mask = (mark_w == mark_hi[ADDR_W-1:6]) ?
                   ({64{1'b1}} >> (6'd63 - mark_hi[5:0])) : {64{1'b1}};

  assign adv_word  = map_rd >> adv_off[5:0];
  assign adv_ones  = trailing_ones(adv_word);
  assign adv_avail = lim - LIM_W'(adv_off);
  assign adv_amt   = (adv_avail < LIM_W'(adv_ones)) ? adv_avail : LIM_W'(adv_ones);

  assign scan_word = pos[ADDR_W-1:6];
  assign scan_mask = {64{1'b1}} >> (6'd63 - pos[5:0]);
  assign scan_cand = (hole ? map_rd : ~map_rd) & scan_mask;
  assign scan_bit  = highest_set(scan_cand);
  assign scan_p    = {scan_word, scan_bit};

  assign blk_wdata = {initial_seq + 32'(right_off) + 32'd1,
                      initial_seq + 32'(scan_p) + 32'd1};

  // Bitmap port control and block list write enable
  always_comb begin
    map_we    = 1'b0;
    map_re    = 1'b0;
    map_waddr = clr_idx;
    map_raddr = mark_w;
    map_wdata = '0;
    blk_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
      end
      S_MARK_RD: begin
        map_re = 1'b1;
      end
      S_MARK_WR: begin
        map_we    = 1'b1;
        map_waddr = mark_w;
        map_wdata = map_rd | (lo_mask & hi_mask);
      end
      S_ADV_RD: begin
        map_re    = (adv_cur < lim32);
        map_raddr = adv_cur[ADDR_W-1:6];
      end
      S_SCAN_RD: begin
        map_re    = 1'b1;
        map_raddr = scan_word;
      end
      S_SCAN_EV: begin
        blk_we = (scan_cand != '0) && !hole && (nb != NB_W'(MAX_BLOCKS));
      end
      default: begin
      end
    endcase
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd <= map_mem[map_raddr];
  end

  // Block list memory
  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[nb[BIDX_W-1:0]] <= blk_wdata;
    if (state == S_OUT_RD) blk_rd <= blk_mem[out_idx[BIDX_W-1:0]];
  end

  assign out_last = res_blk ? (out_idx == nb - NB_W'(1)) : 1'b1;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      initial_seq   <= '0;
      recv_window   <= 16'd65535;
      max_seg_size  <= 16'd1460;
      buffer_limit  <= 17'd65536;
      next_expected <= 32'd1;
      highest_seen  <= '0;
      nb            <= '0;
      out_idx       <= '0;
      hole          <= 1'b0;
      res_blk       <= 1'b0;
      res_status    <= ST_OK;
    end else if (cfg_we && (cfg_addr == REG_INITIAL_SEQ)) begin
      // A new initial sequence starts a fresh session
      initial_seq   <= cfg_data;
      next_expected <= cfg_data + 32'd1;
      highest_seen  <= cfg_data;
      clr_idx       <= '0;
      state         <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + WIDX_W'(1);
          if (clr_idx == WIDX_W'(MAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            seq_r   <= s_tdata[31:0];
            len_r   <= s_tdata[47:32];
            seg_end <= s_tdata[31:0] + 32'(s_tdata[47:32]);
            state   <= S_CHK;
          end
        end
        S_CHK: begin
          nb      <= '0;
          res_blk <= 1'b0;
          out_idx <= '0;
          if (len_r > max_seg_size) begin
            res_status <= ST_OVERSIZE;
            state      <= S_OUT_SEND;
          end else if ((seg_end - initial_seq) > lim32) begin
            res_status <= ST_BUF_OVF;
            state      <= S_OUT_SEND;
          end else begin
            res_status <= ST_OK;
            last_byte  <= seg_end - 32'd1;
            wend       <= next_expected + 32'(recv_window);
            s_off      <= seq_r - initial_seq;
            state      <= S_WIN;
          end
        end
        S_WIN: begin
          if (highest_seen <= last_byte) highest_seen <= last_byte;
          if (len_r == '0) begin
            state <= S_IDLE;
          end else if (win_ok) begin
            if (ms < mend) begin
              mark_lo <= ms[ADDR_W-1:0];
              mark_hi <= ADDR_W'(mend - 32'd1);
              mark_w  <= ms[ADDR_W-1:6];
              state   <= S_MARK_RD;
            end else begin
              state <= S_ADV_RD;
            end
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_WR;
        end
        S_MARK_WR: begin
          if (mark_w == mark_hi[ADDR_W-1:6]) begin
            state <= S_ADV_RD;
          end else begin
            mark_w <= mark_w + WIDX_W'(1);
            state  <= S_MARK_RD;
          end
        end
        S_ADV_RD: begin
          if (adv_cur < lim32) begin
            adv_off <= adv_cur[ADDR_W-1:0];
            state   <= S_ADV_EV;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_ADV_EV: begin
          next_expected <= next_expected + 32'(adv_amt);
          if (adv_ones == 7'd64 - 7'(adv_off[5:0])) state <= S_ADV_RD;
          else state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if ((highest_seen > next_expected) && (top_off < lim32)) begin
            pos       <= top_off[ADDR_W-1:0];
            right_off <= top_off[ADDR_W-1:0];
            hole      <= 1'b0;
            state     <= S_SCAN_RD;
          end else begin
            state <= S_OUT_SEND;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (scan_cand != '0) begin
            if (!hole && (nb == NB_W'(MAX_BLOCKS))) begin
              // Too many holes: drop the run
              res_status <= ST_HOLES;
              state      <= S_OUT_SEND;
            end else begin
              if (!hole) begin
                nb   <= nb + NB_W'(1);
                hole <= 1'b1;
              end else begin
                right_off <= scan_p;
                hole      <= 1'b0;
              end
              if (scan_p == '0) begin
                res_blk <= (nb != '0) || !hole;
                state   <= ((nb != '0) || !hole) ? S_OUT_RD : S_OUT_SEND;
              end else begin
                pos <= scan_p - ADDR_W'(1);
                if (scan_bit == '0) state <= S_SCAN_RD;
              end
            end
          end else if (scan_word == '0) begin
            res_blk <= (nb != '0);
            state   <= (nb != '0) ? S_OUT_RD : S_OUT_SEND;
          end else begin
            pos   <= {scan_word - WIDX_W'(1), 6'h3f};
            state <= S_SCAN_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_SEND;
        end
        S_OUT_SEND: begin
          if (m_tready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + NB_W'(1);
              state   <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Remaining configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_RECV_WINDOW:  recv_window  <= cfg_data[15:0];
          REG_MAX_SEG_SIZE: max_seg_size <= cfg_data[15:0];
          REG_BUFFER_LIMIT: buffer_limit <= cfg_data[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result port
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT_SEND);
  assign m_tuser  = res_blk;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, res_status,
                     res_blk ? blk_rd[63:32] : 32'd0,
                     res_blk ? blk_rd[31:0] : 32'd0,
                     next_expected};

  `TRBS_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid, "input taken while result pending")
  `TRBS_ASSERT_NEVER(a_nb_bound, nb > NB_W'(MAX_BLOCKS), "block count beyond limit")
  `TRBS_ASSERT_IMPLY(a_blk_ok, m_tvalid && m_tuser, res_status == ST_OK, "block with error status")
  `TRBS_ASSERT_NEXT(a_clear_blocks, (state == S_CLEAR) && !cfg_we, !m_tvalid, "result during clear")

endmodule
